### src/cmlcd_pkg.sv
package cmlcd_pkg;

  localparam int HEIGHT_LINES_DEF = 128;
  localparam int ROW_BYTES_DEF    = 48;
  localparam int PIXEL_COLUMNS    = 128;

  localparam logic [2:0] MODE_PIXEL   = 3'd0;
  localparam logic [2:0] MODE_LINE    = 3'd1;
  localparam logic [2:0] MODE_CLEAR   = 3'd2;
  localparam logic [2:0] MODE_DISPLAY = 3'd3;
  localparam logic [2:0] MODE_TICK    = 3'd4;

  localparam logic [1:0] KIND_IDLE    = 2'd0;
  localparam logic [1:0] KIND_LINE    = 2'd1;
  localparam logic [1:0] KIND_CLEAR   = 2'd2;
  localparam logic [1:0] KIND_DISPLAY = 2'd3;

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_ADDRESS = 3'd1;
  localparam logic [2:0] PH_DATA    = 3'd2;
  localparam logic [2:0] PH_DUMMY   = 3'd3;
  localparam logic [2:0] PH_FINAL   = 3'd4;

  localparam logic [7:0] CMD_UPDATE = 8'h80;
  localparam logic [7:0] CMD_CLEAR  = 8'h20;
  localparam logic [7:0] BYTE_WHITE = 8'hFF;

  typedef struct packed {
    logic capture;
    logic exec;
    logic wr0;
    logic wr1;
    logic latch_rd;
    logic clr_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic pix_go;
    logic pix_two;
    logic tick_rd;
    logic out_free;
  } status_t;

endpackage

### src/cmlcd_ctrl.sv
module cmlcd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cmlcd_pkg::status_t sts,
  output cmlcd_pkg::cmd_t    cmd
);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_EXEC = 3'd2;
  localparam logic [2:0] ST_PXB  = 3'd3;
  localparam logic [2:0] ST_PXC  = 3'd4;
  localparam logic [2:0] ST_TKB  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.pix_go) begin
          state_nxt = ST_PXB;
        end else if (sts.tick_rd) begin
          state_nxt = ST_TKB;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_PXB: begin
        cmd.wr0   = 1'b1;
        state_nxt = sts.pix_two ? ST_PXC : ST_FIN;
      end
      ST_PXC: begin
        cmd.wr1   = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_TKB: begin
        cmd.latch_rd = 1'b1;
        state_nxt    = ST_FIN;
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLR;
      end
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

### src/cmlcd_dpath.sv
module cmlcd_dpath #(
  parameter int HEIGHT_LINES = cmlcd_pkg::HEIGHT_LINES_DEF,
  parameter int ROW_BYTES    = cmlcd_pkg::ROW_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmlcd_pkg::cmd_t    cmd,
  output cmlcd_pkg::status_t sts,
  input  logic [2:0]         in_mode,
  input  logic [6:0]         in_pixel_x,
  input  logic [6:0]         in_pixel_y,
  input  logic [2:0]         in_pixel_color,
  input  logic [7:0]         in_first_line,
  input  logic [7:0]         in_last_line,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_byte_valid,
  output logic [7:0]         out_serial_byte,
  output logic               out_select_active,
  output logic               out_end_of_sequence
);

  localparam int DEPTH = HEIGHT_LINES * ROW_BYTES;
  localparam int AW    = $clog2(DEPTH);
  localparam int RIW   = $clog2(ROW_BYTES);

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7 - i];
    end
    return r;
  endfunction

  // captured item
  logic [2:0]    mode_r;
  logic [6:0]    x_r;
  logic [6:0]    y_r;
  logic [2:0]    color_r;
  logic [7:0]    first_r;
  logic [7:0]    last_r;
  logic [AW-1:0] pix_base_r;
  logic [AW-1:0] line_base_r;

  // sequence state
  logic [1:0]     kind_r, kind_nxt;
  logic [2:0]     phase_r, phase_nxt;
  logic [7:0]     cur_r, cur_nxt;
  logic [7:0]     fin_r, fin_nxt;
  logic [RIW-1:0] ridx_r, ridx_nxt;
  logic [AW-1:0]  rbase_r, rbase_nxt;

  // pending result
  logic       res_valid_r, res_valid_nxt;
  logic [7:0] res_byte_r, res_byte_nxt;
  logic       res_sel_r, res_sel_nxt;
  logic       res_eos_r, res_eos_nxt;

  logic          out_valid_r;
  logic          out_bv_r;
  logic [7:0]    out_byte_r;
  logic          out_sel_r;
  logic          out_eos_r;

  logic [7:0]    mem [DEPTH];
  logic [7:0]    mem_rdata_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [AW-1:0] addr_r;
  logic [AW-1:0] addr1;
  logic [AW-1:0] clr_cnt_r;

  logic          busy;
  logic [8:0]    bitpos;
  logic [5:0]    idx;
  logic [2:0]    off;
  logic          pix_in;
  logic [AW-1:0] pix_addr;
  logic [AW-1:0] exec_addr;
  logic [7:0]    last_c;
  logic [15:0]   mask16;
  logic [15:0]   val16;

  assign busy   = (kind_r != cmlcd_pkg::KIND_IDLE);
  assign bitpos = ({2'b0, x_r} << 1) + {2'b0, x_r};
  assign idx    = bitpos[8:3];
  assign off    = bitpos[2:0];
  assign pix_in = (9'(x_r) < 9'(cmlcd_pkg::PIXEL_COLUMNS)) &&
                  (8'(y_r) < 8'(HEIGHT_LINES)) && (7'(idx) < 7'(ROW_BYTES));
  assign pix_addr  = pix_base_r + AW'(idx);
  assign exec_addr = (!busy && mode_r == cmlcd_pkg::MODE_PIXEL) ? pix_addr
                                                                : rbase_r + AW'(ridx_r);
  assign addr1  = addr_r + AW'(1);
  assign last_c = (last_r > 8'(HEIGHT_LINES)) ? 8'(HEIGHT_LINES) : last_r;
  assign mask16 = 16'hE000 >> off;
  assign val16  = {color_r, 13'd0} >> off;

  assign sts.clr_last = (clr_cnt_r == AW'(DEPTH - 1));
  assign sts.pix_go   = !busy && (mode_r == cmlcd_pkg::MODE_PIXEL) && pix_in;
  assign sts.pix_two  = (off > 3'd5) && (7'(idx) + 7'd1 < 7'(ROW_BYTES));
  assign sts.tick_rd  = busy && (mode_r == cmlcd_pkg::MODE_TICK) &&
                        (kind_r == cmlcd_pkg::KIND_LINE) && (phase_r == cmlcd_pkg::PH_DATA);
  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r      <= in_mode;
      x_r         <= in_pixel_x;
      y_r         <= in_pixel_y;
      color_r     <= in_pixel_color;
      first_r     <= in_first_line;
      last_r      <= in_last_line;
      pix_base_r  <= AW'(32'(in_pixel_y) * ROW_BYTES);
      line_base_r <= AW'((32'(in_first_line) - 32'd1) * ROW_BYTES);
    end
    if (cmd.exec) begin
      addr_r <= exec_addr;
    end
  end

  always_comb begin
    kind_nxt      = kind_r;
    phase_nxt     = phase_r;
    cur_nxt       = cur_r;
    fin_nxt       = fin_r;
    ridx_nxt      = ridx_r;
    rbase_nxt     = rbase_r;
    res_valid_nxt = 1'b0;
    res_byte_nxt  = 8'd0;
    res_sel_nxt   = 1'b0;
    res_eos_nxt   = 1'b0;
    if (busy) begin
      res_sel_nxt = 1'b1;
      if (mode_r == cmlcd_pkg::MODE_TICK) begin
        res_valid_nxt = 1'b1;
        if (kind_r == cmlcd_pkg::KIND_LINE) begin
          unique case (phase_r)
            cmlcd_pkg::PH_HEADER: begin
              res_byte_nxt = cmlcd_pkg::CMD_UPDATE;
              phase_nxt    = (cur_r == 8'd0) ? cmlcd_pkg::PH_FINAL : cmlcd_pkg::PH_ADDRESS;
            end
            cmlcd_pkg::PH_ADDRESS: begin
              res_byte_nxt = rev8(cur_r);
              ridx_nxt     = '0;
              phase_nxt    = cmlcd_pkg::PH_DATA;
            end
            cmlcd_pkg::PH_DATA: begin
              ridx_nxt = ridx_r + RIW'(1);
              if (ridx_r == RIW'(ROW_BYTES - 1)) begin
                phase_nxt = cmlcd_pkg::PH_DUMMY;
              end
            end
            cmlcd_pkg::PH_DUMMY: begin
              if (cur_r >= fin_r) begin
                phase_nxt = cmlcd_pkg::PH_FINAL;
              end else begin
                cur_nxt   = cur_r + 8'd1;
                rbase_nxt = rbase_r + AW'(ROW_BYTES);
                phase_nxt = cmlcd_pkg::PH_ADDRESS;
              end
            end
            default: begin
              res_eos_nxt = 1'b1;
            end
          endcase
        end else begin
          if (phase_r == cmlcd_pkg::PH_HEADER) begin
            res_byte_nxt = (kind_r == cmlcd_pkg::KIND_CLEAR) ? cmlcd_pkg::CMD_CLEAR : 8'd0;
            phase_nxt    = cmlcd_pkg::PH_ADDRESS;
          end else begin
            res_eos_nxt = 1'b1;
          end
        end
        if (res_eos_nxt) begin
          kind_nxt  = cmlcd_pkg::KIND_IDLE;
          phase_nxt = cmlcd_pkg::PH_HEADER;
          cur_nxt   = 8'd0;
          fin_nxt   = 8'd0;
          ridx_nxt  = '0;
        end
      end
    end else begin
      unique case (mode_r) inside
        cmlcd_pkg::MODE_LINE: begin
          kind_nxt    = cmlcd_pkg::KIND_LINE;
          phase_nxt   = cmlcd_pkg::PH_HEADER;
          ridx_nxt    = '0;
          res_sel_nxt = 1'b1;
          rbase_nxt   = line_base_r;
          if (first_r == 8'd0 || first_r > last_c) begin
            cur_nxt = 8'd0;
            fin_nxt = 8'd0;
          end else begin
            cur_nxt = first_r;
            fin_nxt = last_c;
          end
        end
        cmlcd_pkg::MODE_CLEAR, cmlcd_pkg::MODE_DISPLAY: begin
          kind_nxt    = (mode_r == cmlcd_pkg::MODE_CLEAR) ? cmlcd_pkg::KIND_CLEAR
                                                          : cmlcd_pkg::KIND_DISPLAY;
          phase_nxt   = cmlcd_pkg::PH_HEADER;
          res_sel_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= cmlcd_pkg::KIND_IDLE;
      phase_r <= cmlcd_pkg::PH_HEADER;
      cur_r   <= 8'd0;
      fin_r   <= 8'd0;
      ridx_r  <= '0;
      rbase_r <= '0;
    end else if (cmd.exec) begin
      kind_r  <= kind_nxt;
      phase_r <= phase_nxt;
      cur_r   <= cur_nxt;
      fin_r   <= fin_nxt;
      ridx_r  <= ridx_nxt;
      rbase_r <= rbase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_valid_r <= res_valid_nxt;
      res_byte_r  <= res_byte_nxt;
      res_sel_r   <= res_sel_nxt;
      res_eos_r   <= res_eos_nxt;
    end else if (cmd.latch_rd) begin
      res_byte_r <= mem_rdata_r;
    end
  end

  // frame store
  always_comb begin
    mem_we    = cmd.clr_step | cmd.wr0 | cmd.wr1;
    mem_waddr = addr_r;
    mem_wdata = (mem_rdata_r & ~mask16[15:8]) | val16[15:8];
    if (cmd.clr_step) begin
      mem_waddr = clr_cnt_r;
      mem_wdata = cmlcd_pkg::BYTE_WHITE;
    end else if (cmd.wr1) begin
      mem_waddr = addr1;
      mem_wdata = (mem_rdata_r & ~mask16[7:0]) | val16[7:0];
    end
    mem_raddr = cmd.exec ? exec_addr : addr1;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_bv_r   <= res_valid_r;
      out_byte_r <= res_byte_r;
      out_sel_r  <= res_sel_r;
      out_eos_r  <= res_eos_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_byte_valid      = out_bv_r;
  assign out_serial_byte     = out_byte_r;
  assign out_select_active   = out_sel_r;
  assign out_end_of_sequence = out_eos_r;

endmodule

### src/color_memory_lcd_frame_controller_core.sv
// Each input beat is captured, executed and then registered at the output; row
// data bytes add a frame store read, pixel writes one or two store writes.
// No new item is taken (in_stall high) until the previous result is loaded.
// Reset: sync active-low; afterwards the store is swept to white one byte per
// cycle with in_stall high.
module color_memory_lcd_frame_controller_core #(
  parameter int HEIGHT_LINES = cmlcd_pkg::HEIGHT_LINES_DEF,
  parameter int ROW_BYTES    = cmlcd_pkg::ROW_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_mode,
  input  logic [6:0] in_pixel_x,
  input  logic [6:0] in_pixel_y,
  input  logic [2:0] in_pixel_color,
  input  logic [7:0] in_first_line,
  input  logic [7:0] in_last_line,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_byte_valid,
  output logic [7:0] out_serial_byte,
  output logic       out_select_active,
  output logic       out_end_of_sequence
);

  cmlcd_pkg::cmd_t    cmd;
  cmlcd_pkg::status_t sts;

  cmlcd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  cmlcd_dpath #(
    .HEIGHT_LINES (HEIGHT_LINES),
    .ROW_BYTES    (ROW_BYTES)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_mode             (in_mode),
    .in_pixel_x          (in_pixel_x),
    .in_pixel_y          (in_pixel_y),
    .in_pixel_color      (in_pixel_color),
    .in_first_line       (in_first_line),
    .in_last_line        (in_last_line),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_byte_valid      (out_byte_valid),
    .out_serial_byte     (out_serial_byte),
    .out_select_active   (out_select_active),
    .out_end_of_sequence (out_end_of_sequence)
  );

endmodule
